// File: rtl/core/vrr_pkg.sv
package vrr_pkg;

   // field format, signed fixed point (Q4.12)
   localparam int COMP_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   // internal widths, sized from the value ranges that the field format allows
   localparam int PROD_W = 2 * COMP_WIDTH;      // dir * norm
   localparam int DOT_W  = 23;                  // dot product and clipped cosine
   localparam int W_W    = 26;                  // v +/- scaled normal
   localparam int P_W    = 28;                  // scaled perpendicular part
   localparam int SQ_W   = 44;                  // rounded square of one component
   localparam int LSQ_W  = 46;                  // squared length and its distance from one
   localparam int ROOT_W = 28;                  // square root result
   localparam int SN_W   = 32;                  // root * norm, rounded
   localparam int O_W    = 34;                  // unclamped result

   localparam logic OP_REFLECT = 1'b0;
   localparam logic OP_REFRACT = 1'b1;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;

endpackage

// File: rtl/core/vrr_sqrt.sv
module vrr_sqrt #(
   parameter int ROOT_W = vrr_pkg::ROOT_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int CND_W = REM_W + 2;

   // one result bit per stage, restoring method
   logic              vld_ff  [1:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff [1:ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [1:ROOT_W];

   logic              cur_vld  [ROOT_W];
   logic [REM_W-1:0]  cur_rem  [ROOT_W];
   logic [ROOT_W-1:0] cur_root [ROOT_W];
   logic [RAD_W-1:0]  cur_rad  [ROOT_W];

   assign cur_vld[0]  = in_valid;
   assign cur_rem[0]  = '0;
   assign cur_root[0] = '0;
   assign cur_rad[0]  = in_rad;

   for (genvar k = 1; k < ROOT_W; k++) begin : g_link
      assign cur_vld[k]  = vld_ff[k];
      assign cur_rem[k]  = rem_ff[k];
      assign cur_root[k] = root_ff[k];
      assign cur_rad[k]  = rad_ff[k];
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [CND_W-1:0] cand_in;
      logic [CND_W-1:0] trial_in;
      logic [CND_W-1:0] diff_in;
      logic             take_in;

      always_comb begin
         cand_in  = {cur_rem[k], cur_rad[k][RAD_W-1 -: 2]};
         trial_in = CND_W'({cur_root[k], 2'b01});
         diff_in  = cand_in - trial_in;
         take_in  = (cand_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= cur_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take_in ? diff_in[REM_W-1:0] : cand_in[REM_W-1:0];
         root_ff[k+1] <= {cur_root[k][ROOT_W-2:0], take_in};
         rad_ff[k+1]  <= {cur_rad[k][RAD_W-3:0], 2'b00};
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];

endmodule

// File: rtl/core/vector_reflect_refract.sv
// an item passes the input capture, stages 2 to 8, the square root pipeline, stage 9 and the output register
// throughput: one item per cycle, busy is never raised and the pipeline never stalls
// depth is set by the square root pipeline, one root bit per stage (28 stages)
// reset clears every valid bit in the pipeline; items in flight are dropped
module vector_reflect_refract (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_dir_x,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_dir_y,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_dir_z,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_norm_x,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_norm_y,
   input  logic signed [vrr_pkg::COMP_WIDTH-1:0] req_norm_z,
   input  logic        [vrr_pkg::COMP_WIDTH-1:0] req_eta_ratio,
   output logic                                  rsp_strobe,
   output logic signed [vrr_pkg::COMP_WIDTH-1:0] rsp_out_x,
   output logic signed [vrr_pkg::COMP_WIDTH-1:0] rsp_out_y,
   output logic signed [vrr_pkg::COMP_WIDTH-1:0] rsp_out_z,
   output logic                                  rsp_saturated
);

   localparam int CW     = vrr_pkg::COMP_WIDTH;
   localparam int FB     = vrr_pkg::FRAC_BITS;
   localparam int PROD_W = vrr_pkg::PROD_W;
   localparam int DOT_W  = vrr_pkg::DOT_W;
   localparam int W_W    = vrr_pkg::W_W;
   localparam int P_W    = vrr_pkg::P_W;
   localparam int SQ_W   = vrr_pkg::SQ_W;
   localparam int LSQ_W  = vrr_pkg::LSQ_W;
   localparam int ROOT_W = vrr_pkg::ROOT_W;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int SN_W   = vrr_pkg::SN_W;
   localparam int O_W    = vrr_pkg::O_W;
   localparam int M4_W   = DOT_W + CW;
   localparam int M6_W   = CW + 1 + W_W;
   localparam int M7_W   = 2 * P_W;
   localparam int M9_W   = ROOT_W + 1 + CW;

   localparam logic signed [PROD_W-1:0] H2     = PROD_W'(1) <<< (FB - 1);
   localparam logic signed [DOT_W-1:0]  ONE3   = DOT_W'(1) <<< FB;
   localparam logic signed [M4_W-1:0]   H4_RFR = M4_W'(1) <<< (FB - 1);
   localparam logic signed [M4_W-1:0]   H4_RFL = M4_W'(1) <<< (FB - 2);
   localparam logic signed [M6_W-1:0]   H6     = M6_W'(1) <<< (FB - 1);
   localparam logic signed [M7_W-1:0]   H7     = M7_W'(1) <<< (FB - 1);
   localparam logic signed [LSQ_W-1:0]  ONE8   = LSQ_W'(1) <<< FB;
   localparam logic signed [M9_W-1:0]   H9     = M9_W'(1) <<< (FB - 1);
   localparam logic signed [O_W-1:0]    OMAX   = (O_W'(1) <<< (CW - 1)) - O_W'(1);
   localparam logic signed [O_W-1:0]    OMIN   = -(O_W'(1) <<< (CW - 1));

   assign busy = 1'b0;

   // stage 1: input capture
   logic              vld1_ff, op1_ff;
   vrr_pkg::comp_type dir1_ff [3];
   vrr_pkg::comp_type nrm1_ff [3];
   logic [CW-1:0]     eta1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff     <= req_operation;
      dir1_ff[0] <= req_dir_x;
      dir1_ff[1] <= req_dir_y;
      dir1_ff[2] <= req_dir_z;
      nrm1_ff[0] <= req_norm_x;
      nrm1_ff[1] <= req_norm_y;
      nrm1_ff[2] <= req_norm_z;
      eta1_ff    <= req_eta_ratio;
   end

   // stage 2: rounded products of dot(v, n)
   logic                    vld2_ff, op2_ff;
   vrr_pkg::comp_type       dir2_ff [3];
   vrr_pkg::comp_type       nrm2_ff [3];
   logic [CW-1:0]           eta2_ff;
   logic signed [DOT_W-1:0] dot2_ff [3];
   logic signed [DOT_W-1:0] dot2_in [3];
   logic signed [PROD_W-1:0] mul2   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul2[i]    = dir1_ff[i] * nrm1_ff[i];
         dot2_in[i] = DOT_W'((mul2[i] + H2) >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      op2_ff  <= op1_ff;
      dir2_ff <= dir1_ff;
      nrm2_ff <= nrm1_ff;
      eta2_ff <= eta1_ff;
      dot2_ff <= dot2_in;
   end

   // stage 3: dot sum, cosine for refract
   logic                    vld3_ff, op3_ff;
   vrr_pkg::comp_type       dir3_ff [3];
   vrr_pkg::comp_type       nrm3_ff [3];
   logic [CW-1:0]           eta3_ff;
   logic signed [DOT_W-1:0] k3_ff, k3_in, dsum3, negd3;

   always_comb begin
      dsum3 = dot2_ff[0] + dot2_ff[1] + dot2_ff[2];
      negd3 = -dsum3;
      k3_in = (op2_ff == vrr_pkg::OP_REFRACT) ? ((negd3 > ONE3) ? ONE3 : negd3) : dsum3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      op3_ff  <= op2_ff;
      dir3_ff <= dir2_ff;
      nrm3_ff <= nrm2_ff;
      eta3_ff <= eta2_ff;
      k3_ff   <= k3_in;
   end

   // stage 4: scaled normal, reflect doubles it through a shorter shift
   logic                  vld4_ff, op4_ff;
   vrr_pkg::comp_type     dir4_ff [3];
   vrr_pkg::comp_type     nrm4_ff [3];
   logic [CW-1:0]         eta4_ff;
   logic signed [W_W-1:0] t4_ff [3];
   logic signed [W_W-1:0] t4_in [3];
   logic signed [M4_W-1:0] mul4 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul4[i] = k3_ff * nrm3_ff[i];
         if (op3_ff == vrr_pkg::OP_REFRACT) begin
            t4_in[i] = W_W'((mul4[i] + H4_RFR) >>> FB);
         end else begin
            t4_in[i] = W_W'((mul4[i] + H4_RFL) >>> (FB - 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op4_ff  <= op3_ff;
      dir4_ff <= dir3_ff;
      nrm4_ff <= nrm3_ff;
      eta4_ff <= eta3_ff;
      t4_ff   <= t4_in;
   end

   // stage 5: v + c*n for refract, v - 2*d*n for reflect
   logic                  vld5_ff, op5_ff;
   vrr_pkg::comp_type     nrm5_ff [3];
   logic [CW-1:0]         eta5_ff;
   logic signed [W_W-1:0] w5_ff [3];
   logic signed [W_W-1:0] w5_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (op4_ff == vrr_pkg::OP_REFRACT) begin
            w5_in[i] = W_W'(dir4_ff[i]) + t4_ff[i];
         end else begin
            w5_in[i] = W_W'(dir4_ff[i]) - t4_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      op5_ff  <= op4_ff;
      nrm5_ff <= nrm4_ff;
      eta5_ff <= eta4_ff;
      w5_ff   <= w5_in;
   end

   // stage 6: scale by eta; reflect result passes through
   logic                   vld6_ff, op6_ff;
   vrr_pkg::comp_type      nrm6_ff [3];
   logic signed [P_W-1:0]  p6_ff [3];
   logic signed [P_W-1:0]  p6_in [3];
   logic signed [M6_W-1:0] mul6 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul6[i] = $signed({1'b0, eta5_ff}) * w5_ff[i];
         if (op5_ff == vrr_pkg::OP_REFRACT) begin
            p6_in[i] = P_W'((mul6[i] + H6) >>> FB);
         end else begin
            p6_in[i] = P_W'(w5_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      op6_ff  <= op5_ff;
      nrm6_ff <= nrm5_ff;
      p6_ff   <= p6_in;
   end

   // stage 7: squares of the perpendicular part
   logic                   vld7_ff, op7_ff;
   vrr_pkg::comp_type      nrm7_ff [3];
   logic signed [P_W-1:0]  p7_ff [3];
   logic signed [SQ_W-1:0] sq7_ff [3];
   logic signed [SQ_W-1:0] sq7_in [3];
   logic signed [M7_W-1:0] mul7 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul7[i]   = p6_ff[i] * p6_ff[i];
         sq7_in[i] = SQ_W'((mul7[i] + H7) >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld7_ff <= 1'b0;
      end else begin
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      op7_ff  <= op6_ff;
      nrm7_ff <= nrm6_ff;
      p7_ff   <= p6_ff;
      sq7_ff  <= sq7_in;
   end

   // stage 8: |1 - |p|^2| scaled up as the root operand
   logic                    vld8_ff, op8_ff;
   vrr_pkg::comp_type       nrm8_ff [3];
   logic signed [P_W-1:0]   p8_ff [3];
   logic [RAD_W-1:0]        rad8_ff, rad8_in;
   logic signed [LSQ_W-1:0] lsq8, diff8, mag8;

   always_comb begin
      lsq8    = LSQ_W'(sq7_ff[0]) + LSQ_W'(sq7_ff[1]) + LSQ_W'(sq7_ff[2]);
      diff8   = ONE8 - lsq8;
      mag8    = (diff8 < 0) ? -diff8 : diff8;
      rad8_in = RAD_W'(mag8) << FB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld8_ff <= 1'b0;
      end else begin
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      op8_ff  <= op7_ff;
      nrm8_ff <= nrm7_ff;
      p8_ff   <= p7_ff;
      rad8_ff <= rad8_in;
   end

   // square root, with the rest of the item in a matching delay line
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;

   vrr_sqrt #(
      .ROOT_W(ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld8_ff),
      .in_rad   (rad8_ff),
      .out_valid(sq_vld),
      .out_root (sq_root)
   );

   logic                  dl_op_ff  [ROOT_W];
   vrr_pkg::comp_type     dl_nrm_ff [ROOT_W][3];
   logic signed [P_W-1:0] dl_p_ff   [ROOT_W][3];

   always_ff @(posedge clock) begin
      dl_op_ff[0]  <= op8_ff;
      dl_nrm_ff[0] <= nrm8_ff;
      dl_p_ff[0]   <= p8_ff;
      for (int k = 1; k < ROOT_W; k++) begin
         dl_op_ff[k]  <= dl_op_ff[k-1];
         dl_nrm_ff[k] <= dl_nrm_ff[k-1];
         dl_p_ff[k]   <= dl_p_ff[k-1];
      end
   end

   // stage 9: root * n
   logic                   vld9_ff, op9_ff;
   logic signed [P_W-1:0]  p9_ff [3];
   logic signed [SN_W-1:0] sn9_ff [3];
   logic signed [SN_W-1:0] sn9_in [3];
   logic signed [M9_W-1:0] mul9 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul9[i]   = $signed({1'b0, sq_root}) * dl_nrm_ff[ROOT_W-1][i];
         sn9_in[i] = SN_W'((mul9[i] + H9) >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld9_ff <= 1'b0;
      end else begin
         vld9_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      op9_ff <= dl_op_ff[ROOT_W-1];
      p9_ff  <= dl_p_ff[ROOT_W-1];
      sn9_ff <= sn9_in;
   end

   // stage 10: final subtract for refract and output clamp
   logic signed [O_W-1:0] o10 [3];
   logic signed [CW-1:0]  out10_in [3];
   logic                  sat10_in;
   logic signed [CW-1:0]  out_ff [3];
   logic                  sat_ff, strobe_ff;

   always_comb begin
      sat10_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (op9_ff == vrr_pkg::OP_REFRACT) begin
            o10[i] = O_W'(p9_ff[i]) - O_W'(sn9_ff[i]);
         end else begin
            o10[i] = O_W'(p9_ff[i]);
         end
         if (o10[i] > OMAX) begin
            out10_in[i] = CW'(OMAX);
            sat10_in    = 1'b1;
         end else if (o10[i] < OMIN) begin
            out10_in[i] = CW'(OMIN);
            sat10_in    = 1'b1;
         end else begin
            out10_in[i] = CW'(o10[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld9_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out10_in;
      sat_ff <= sat10_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int LATENCY   = 37;
   localparam int WATCH_MAX = 2000;
   localparam int CWID      = vrr_pkg::COMP_WIDTH;
   localparam int FB        = vrr_pkg::FRAC_BITS;
   localparam longint ONE   = longint'(1) << FB;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;

   typedef struct packed {
      logic              sat;
      vrr_pkg::comp_type x;
      vrr_pkg::comp_type y;
      vrr_pkg::comp_type z;
   } ray_out_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_operation = vrr_pkg::OP_REFLECT;
   vrr_pkg::comp_type req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   vrr_pkg::comp_type req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic [CWID-1:0] req_eta_ratio = 0;
   logic rsp_strobe;
   vrr_pkg::comp_type rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_saturated;

   ray_out_type expected_rays[$];
   int errors = 0;
   int rays_sent = 0, refracts_sent = 0, rays_checked = 0, clipped_seen = 0;
   int idle_pct = 35;
   int quiet_cycles = 0;

   vector_reflect_refract DUT (.*);

   always #5 clock = ~clock;

   function automatic longint rnd_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi, ref bit flag);
      if (x < lo) begin
         flag = 1;
         return lo;
      end
      if (x > hi) begin
         flag = 1;
         return hi;
      end
      return x;
   endfunction

   function automatic longint isqrt(longint x);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic ray_out_type trace_ray(logic op, vrr_pkg::comp_type dv[3],
                                             vrr_pkg::comp_type nv[3],
                                             logic [CWID-1:0] eta_bits);
      longint v[3], n[3], o[3], p[3];
      longint d, c, u, lsq, x, s, eta, lo, hi;
      bit sat;
      ray_out_type r;
      sat = 0;
      d = 0;
      eta = longint'(eta_bits);
      lo = -(longint'(1) << (CWID - 1));
      hi = (longint'(1) << (CWID - 1)) - 1;
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'(dv[i]);
         n[i] = longint'(nv[i]);
         d += rnd_shift(v[i] * n[i], FB);
      end
      if (op == vrr_pkg::OP_REFLECT) begin
         d = clamp(d, S32_LO, S32_HI, sat);
         for (int i = 0; i < 3; i++) o[i] = v[i] - rnd_shift(d * n[i], FB - 1);
      end else begin
         c = clamp(-d, S32_LO, S32_HI, sat);
         if (c > ONE) c = ONE;
         lsq = 0;
         for (int i = 0; i < 3; i++) begin
            u = clamp(v[i] + rnd_shift(c * n[i], FB), S32_LO, S32_HI, sat);
            p[i] = clamp(rnd_shift(eta * u, FB), S32_LO, S32_HI, sat);
            lsq += rnd_shift(p[i] * p[i], FB);
         end
         x = ONE - lsq;
         if (x < 0) x = -x;
         x = clamp(x, 0, (longint'(1) << (63 - FB)) - 1, sat);
         s = isqrt(x << FB);
         s = clamp(s, 0, S32_HI, sat);
         for (int i = 0; i < 3; i++) o[i] = p[i] - rnd_shift(s * n[i], FB);
      end
      r.x = vrr_pkg::comp_type'(clamp(o[0], lo, hi, sat));
      r.y = vrr_pkg::comp_type'(clamp(o[1], lo, hi, sat));
      r.z = vrr_pkg::comp_type'(clamp(o[2], lo, hi, sat));
      r.sat = sat;
      return r;
   endfunction

   task automatic send_ray(logic op, vrr_pkg::comp_type dv[3], vrr_pkg::comp_type nv[3],
                           logic [CWID-1:0] eta_bits);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_dir_x <= dv[0];
      req_dir_y <= dv[1];
      req_dir_z <= dv[2];
      req_norm_x <= nv[0];
      req_norm_y <= nv[1];
      req_norm_z <= nv[2];
      req_eta_ratio <= eta_bits;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rays.push_back(trace_ray(op, dv, nv, eta_bits));
      rays_sent++;
      if (op == vrr_pkg::OP_REFRACT) refracts_sent++;
      // start stays up so the next item can follow without a gap
      @(negedge clock);
   endtask

   function automatic vrr_pkg::comp_type rand_comp();
      return vrr_pkg::comp_type'($urandom_range(16'hffff));
   endfunction

   // unit-ish vector with random direction, length near one
   function automatic void rand_unit(ref vrr_pkg::comp_type w[3]);
      int a, b, c;
      a = int'($urandom_range(8192)) - 4096;
      b = int'($urandom_range(8192)) - 4096;
      c = 4096 - (a < 0 ? -a : a) / 2 - (b < 0 ? -b : b) / 2;
      if ($urandom_range(1)) c = -c;
      w[0] = vrr_pkg::comp_type'(a);
      w[1] = vrr_pkg::comp_type'(b);
      w[2] = vrr_pkg::comp_type'(c);
   endfunction

   task automatic test_directed();
      vrr_pkg::comp_type dv[3], nv[3];
      vrr_pkg::comp_type ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh1000};
      dv = '{16'sh1000, 16'sh0000, -16'sh1000};
      nv = '{16'sh0000, 16'sh0000, 16'sh1000};
      send_ray(vrr_pkg::OP_REFLECT, dv, nv, 16'hffff);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'h1000);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'h0000);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'hffff);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'h0aab);
      // degenerate normal
      nv = '{0, 0, 0};
      send_ray(vrr_pkg::OP_REFLECT, dv, nv, 16'h1000);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'h1000);
      // field extremes
      foreach (ext[i]) begin
         dv = '{ext[i], ext[3-i], ext[i]};
         nv = '{ext[3-i], ext[i], ext[i]};
         send_ray(vrr_pkg::OP_REFLECT, dv, nv, 16'h8000);
         send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'h8000);
         send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'hffff);
      end
      dv = '{16'sh8000, 16'sh8000, 16'sh8000};
      nv = '{16'sh8000, 16'sh8000, 16'sh8000};
      send_ray(vrr_pkg::OP_REFLECT, dv, nv, 16'h0000);
      send_ray(vrr_pkg::OP_REFRACT, dv, nv, 16'hffff);
   endtask

   task automatic test_random(int count, int pct);
      vrr_pkg::comp_type dv[3], nv[3];
      logic op;
      logic [CWID-1:0] eta_bits;
      idle_pct = pct;
      repeat (count) begin
         op = logic'($urandom_range(1));
         if ($urandom_range(99) < 75) begin
            rand_unit(dv);
            rand_unit(nv);
            eta_bits = 16'($urandom_range(12000, 2000));
         end else begin
            foreach (dv[i]) dv[i] = rand_comp();
            foreach (nv[i]) nv[i] = rand_comp();
            eta_bits = 16'($urandom_range(16'hffff));
         end
         send_ray(op, dv, nv, eta_bits);
      end
      idle_pct = 35;
   endtask

   always @(posedge clock) begin
      ray_out_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rays.size() == 0) begin
            $error("unexpected result x=%0d y=%0d z=%0d", rsp_out_x, rsp_out_y, rsp_out_z);
            errors++;
         end else begin
            e = expected_rays.pop_front();
            rays_checked++;
            if (rsp_saturated) clipped_seen++;
            if (rsp_out_x !== e.x) begin
               $error("out_x expected %0d actual %0d", e.x, rsp_out_x);
               errors++;
            end
            if (rsp_out_y !== e.y) begin
               $error("out_y expected %0d actual %0d", e.y, rsp_out_y);
               errors++;
            end
            if (rsp_out_z !== e.z) begin
               $error("out_z expected %0d actual %0d", e.z, rsp_out_z);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated expected %0b actual %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without an accepted item or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCH_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_random(600, 35);
      test_random(300, 0);
      test_random(400, 35);
      start <= 0;
      while (expected_rays.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("sent %0d rays (%0d refract), checked %0d results, %0d clipped",
               rays_sent, refracts_sent, rays_checked, clipped_seen);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/vrr_pkg.sv
rtl/core/vrr_sqrt.sv
rtl/core/vector_reflect_refract.sv
bench/testbench.sv
